@@ design/lsfind_pkg.sv @@
// Shared types and constants for the largest free square finder.
`timescale 1ns / 1ps

package lsfind_pkg;

  localparam int unsigned SIZE_W = 11;
  localparam int unsigned POS_W = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIM_W = 17;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_ROWS = 1'b0,
    REG_MAP_COLS = 1'b1
  } cfg_reg_e;

endpackage

@@ design/lsfind_if.sv @@
// Stream and configuration channel interfaces of the largest free square finder.
`timescale 1ns / 1ps

interface lsfind_cell_if;
  logic valid;
  logic ready;
  logic cell_free;

  modport source (output valid, output cell_free, input ready);
  modport sink (input valid, input cell_free, output ready);
endinterface

interface lsfind_result_if;
  logic                 valid;
  logic                 ready;
  lsfind_pkg::size_t    cell_size;
  lsfind_pkg::size_t    best_size;
  lsfind_pkg::pos_t     best_row;
  lsfind_pkg::pos_t     best_col;
  logic                 map_done;

  modport source (output valid, output cell_size, output best_size, output best_row,
                  output best_col, output map_done, input ready);
  modport sink (input valid, input cell_size, input best_size, input best_row,
                input best_col, input map_done, output ready);
endinterface

interface lsfind_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lsfind_pkg::CFG_IDX_W-1:0]     index;
  logic [lsfind_pkg::SIZE_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/largest_square_finder_top.sv @@
// Top level of the streaming largest free square finder.
//
//   Port   Direction  Payload                                           Role
//   in_i   sink       cell_free                                         map cells, row-major
//   out_o  source     cell_size best_size best_row best_col map_done    one result per cell
//   cfg_i  sink       index data                                        map_rows, map_cols
//
// A cell is accepted every cycle unless the output stalls; its result is registered.
// The line buffer read issues at acceptance and the size is computed in the next cycle.
// The left and diagonal size registers close a loop within the compute stage.
// A stalled output holds the compute stage, and then the input, without losing a transaction.
// Reset clears the counters, neighbors and best; the line buffer needs no clearing.
`timescale 1ns / 1ps

module largest_square_finder_top #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lsfind_cell_if.sink      in_i,
  lsfind_result_if.source  out_o,
  lsfind_cfg_if.sink       cfg_i
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DW = lsfind_pkg::DIM_W;
  localparam int unsigned SW = lsfind_pkg::SIZE_W;

  lsfind_pkg::size_t map_rows_q, map_cols_q;
  logic [DW-1:0]     rows_eff, cols_eff;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [DW-1:0] col_p1, row_p1;
  logic          row_end, map_end;

  logic          s0_valid_q, s0_free_q, s0_first_q, s0_row_end_q, s0_map_end_q;
  logic [CW-1:0] s0_col_q;
  logic [RW-1:0] s0_row_q;

  lsfind_pkg::size_t left_q, diag_q, top_size_q, above;
  logic [RW-1:0]     top_row_q;
  logic [CW-1:0]     top_col_q;

  lsfind_pkg::size_t m_lu, m_all, size;
  logic [SW:0]       size_raw;
  logic              better;

  logic              out_valid_q, out_done_q;
  lsfind_pkg::size_t out_size_q, out_best_q;
  lsfind_pkg::pos_t  out_row_q, out_col_q;

  logic in_acc, adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q <= lsfind_pkg::size_t'(1);
      map_cols_q <= lsfind_pkg::size_t'(1);
    end else if (cfg_i.valid) begin
      unique case (lsfind_pkg::cfg_reg_e'(cfg_i.index))
        lsfind_pkg::REG_MAP_ROWS: map_rows_q <= cfg_i.data;
        lsfind_pkg::REG_MAP_COLS: map_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_rows_q == '0) begin
      rows_eff = DW'(1);
    end else if (DW'(map_rows_q) > DW'(MAX_ROWS)) begin
      rows_eff = DW'(MAX_ROWS);
    end else begin
      rows_eff = DW'(map_rows_q);
    end
    if (map_cols_q == '0) begin
      cols_eff = DW'(1);
    end else if (DW'(map_cols_q) > DW'(MAX_COLS)) begin
      cols_eff = DW'(MAX_COLS);
    end else begin
      cols_eff = DW'(map_cols_q);
    end
  end

  assign adv       = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || adv;
  assign in_acc    = in_i.valid && in_i.ready;

  assign col_p1  = DW'(col_q) + DW'(1);
  assign row_p1  = DW'(row_q) + DW'(1);
  assign row_end = (col_p1 >= cols_eff);
  assign map_end = row_end && (row_p1 >= rows_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (map_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (row_end) begin
        col_q <= '0;
        row_q <= row_p1[RW-1:0];
      end else begin
        col_q <= col_p1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_acc) begin
      s0_valid_q <= 1'b1;
    end else if (adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_free_q    <= in_i.cell_free;
      s0_first_q   <= (col_q == '0) || (row_q == '0);
      s0_row_end_q <= row_end;
      s0_map_end_q <= map_end;
      s0_col_q     <= col_q;
      s0_row_q     <= row_q;
    end
  end

  lsfind_line_mem #(
    .DEPTH(MAX_COLS),
    .AW   (CW)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_addr_i(col_q),
    .wr_en_i  (adv),
    .wr_addr_i(s0_col_q),
    .wr_data_i(size),
    .rd_data_o(above)
  );

  always_comb begin
    m_lu     = (left_q < above) ? left_q : above;
    m_all    = (m_lu < diag_q) ? m_lu : diag_q;
    size_raw = {1'b0, m_all} + (SW+1)'(1);
    if (!s0_free_q) begin
      size = '0;
    end else if (s0_first_q) begin
      size = lsfind_pkg::size_t'(1);
    end else if (size_raw[SW]) begin
      size = lsfind_pkg::SIZE_MAX;
    end else begin
      size = size_raw[SW-1:0];
    end
    better = (size > top_size_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      diag_q     <= '0;
      top_size_q <= '0;
      top_row_q  <= '0;
      top_col_q  <= '0;
    end else if (adv) begin
      left_q <= s0_row_end_q ? '0 : size;
      diag_q <= s0_row_end_q ? '0 : above;
      if (s0_map_end_q) begin
        top_size_q <= '0;
        top_row_q  <= '0;
        top_col_q  <= '0;
      end else if (better) begin
        top_size_q <= size;
        top_row_q  <= s0_row_q;
        top_col_q  <= s0_col_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_size_q <= size;
      out_best_q <= better ? size : top_size_q;
      out_row_q  <= better ? lsfind_pkg::pos_t'(s0_row_q) : lsfind_pkg::pos_t'(top_row_q);
      out_col_q  <= better ? lsfind_pkg::pos_t'(s0_col_q) : lsfind_pkg::pos_t'(top_col_q);
      out_done_q <= s0_map_end_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cell_size = out_size_q;
  assign out_o.best_size = out_best_q;
  assign out_o.best_row  = out_row_q;
  assign out_o.best_col  = out_col_q;
  assign out_o.map_done  = out_done_q;

  a_map_end_clears_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s0_map_end_q) |=> (top_size_q == '0 && left_q == '0 && diag_q == '0))
    else $error("best and neighbors not cleared after the last cell of a map");

  a_cell_within_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_size_q <= out_best_q))
    else $error("cell size exceeds the reported best size");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s0_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  a_left_tracks_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !s0_row_end_q) |=> (left_q == $past(size)))
    else $error("left neighbor size not taken from the previous cell");

endmodule

@@ design/lsfind_line_mem.sv @@
// Line buffer memory holding the square sizes of the previous row, with write forwarding.
`timescale 1ns / 1ps

module lsfind_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  lsfind_pkg::size_t     wr_data_i,
  output lsfind_pkg::size_t     rd_data_o
);

  lsfind_pkg::size_t mem_q [DEPTH];
  lsfind_pkg::size_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the largest free square finder: directed table, extreme map sizes and random maps.
`timescale 1ns / 1ps

module tb;
  import lsfind_pkg::*;

  localparam int unsigned GRID_COLS = 1024;
  localparam int unsigned GRID_ROWS = 1024;
  localparam int unsigned TALL_ROWS = 120;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned CALM_ITEMS = 150;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_TAIL = 10;
  localparam longint unsigned LIMIT_NS = 4_000_000;

  typedef struct packed {
    size_t cell_size;
    size_t best_size;
    pos_t  best_row;
    pos_t  best_col;
    logic  map_done;
  } square_result_t;

  typedef enum logic {STEP_CFG, STEP_CELL} step_kind_e;

  typedef struct packed {
    step_kind_e     kind;
    cfg_reg_e       reg_idx;
    size_t          value;
    logic           typed;
    square_result_t want;
  } plan_row_t;

  localparam square_result_t NO_RESULT = '0;

  localparam plan_row_t PLAN [25] = '{
    '{STEP_CELL, REG_MAP_ROWS, 11'd0, 1'b1, '{11'd0, 11'd0, 10'd0, 10'd0, 1'b1}},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b1}},
    '{STEP_CFG, REG_MAP_ROWS, 11'd0, 1'b0, NO_RESULT},
    '{STEP_CFG, REG_MAP_COLS, 11'd0, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b1}},
    '{STEP_CFG, REG_MAP_ROWS, 11'd2, 1'b0, NO_RESULT},
    '{STEP_CFG, REG_MAP_COLS, 11'd2, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b1, '{11'd2, 11'd2, 10'd1, 10'd1, 1'b1}},
    '{STEP_CFG, REG_MAP_ROWS, 11'd2047, 1'b0, NO_RESULT},
    '{STEP_CFG, REG_MAP_COLS, 11'd2047, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CFG, REG_MAP_COLS, 11'd3, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd0, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CFG, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CFG, REG_MAP_COLS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{STEP_CELL, REG_MAP_ROWS, 11'd0, 1'b1, '{11'd0, 11'd0, 10'd0, 10'd0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  lsfind_cell_if   cell_ch ();
  lsfind_result_if res_ch ();
  lsfind_cfg_if    cfg_ch ();

  largest_square_finder_top #(
    .MAX_COLS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cell_ch),
    .out_o (res_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  size_t          line_sizes [GRID_COLS];
  size_t          left_sz;
  size_t          diag_sz;
  size_t          best_sz;
  int unsigned    col_at;
  int unsigned    row_at;
  int unsigned    best_r;
  int unsigned    best_c;
  size_t          rows_cfg;
  size_t          cols_cfg;
  square_result_t expected_results [$];
  int unsigned    error_count;
  bit             hold_request;
  bit             calm;
  bit             gaps_on;

  task automatic flag_error(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void restart_map();
    left_sz = '0;
    diag_sz = '0;
    col_at = 0;
    row_at = 0;
    best_sz = '0;
    best_r = 0;
    best_c = 0;
  endfunction

  function automatic square_result_t square_step(logic free);
    int unsigned    rows_lim;
    int unsigned    cols_lim;
    int unsigned    slot;
    size_t          above;
    size_t          lo;
    size_t          sz;
    logic           row_end;
    logic           map_end;
    square_result_t r;
    rows_lim = (rows_cfg == 0) ? 1 : ((rows_cfg > GRID_ROWS) ? GRID_ROWS : rows_cfg);
    cols_lim = (cols_cfg == 0) ? 1 : ((cols_cfg > GRID_COLS) ? GRID_COLS : cols_cfg);
    slot = col_at % GRID_COLS;
    above = line_sizes[slot];
    if (!free) begin
      sz = '0;
    end else if (row_at == 0 || col_at == 0) begin
      sz = size_t'(1);
    end else begin
      lo = left_sz;
      if (above < lo) lo = above;
      if (diag_sz < lo) lo = diag_sz;
      sz = (lo == SIZE_MAX) ? SIZE_MAX : lo + size_t'(1);
    end
    line_sizes[slot] = sz;
    diag_sz = above;
    left_sz = sz;
    if (sz > best_sz) begin
      best_sz = sz;
      best_r = row_at;
      best_c = col_at;
    end
    row_end = (col_at + 1 >= cols_lim);
    map_end = row_end && (row_at + 1 >= rows_lim);
    r = '{sz, best_sz, pos_t'(best_r), pos_t'(best_c), map_end};
    if (map_end) begin
      restart_map();
    end else if (row_end) begin
      col_at = 0;
      row_at++;
      left_sz = '0;
      diag_sz = '0;
    end else begin
      col_at++;
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    if (calm || !gaps_on || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 10);
  endfunction

  function automatic size_t pick_dim(int unsigned limit);
    if ($urandom_range(0, 9) == 0) return '0;
    return size_t'($urandom_range(1, limit));
  endfunction

  task automatic settle();
    cell_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, size_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAP_ROWS) rows_cfg = val;
    else cols_cfg = val;
  endtask

  task automatic send_cell(input logic free, input int unsigned gap, input bit given,
                           input square_result_t want, output square_result_t predicted);
    if (gap != 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.cell_free <= free;
    do @(posedge clk); while (!cell_ch.ready);
    predicted = square_step(free);
    expected_results.push_back(given ? want : predicted);
  endtask

  initial begin : result_sink
    bit stall_mode;
    bit hold_done;
    stall_mode = 1'b1;
    hold_done = 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && stall_mode && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
        if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
      end
    end
  end

  always @(posedge clk) begin : result_check
    square_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        flag_error("result transaction with no expectation pending");
      end else begin
        want = expected_results.pop_front();
        if (res_ch.cell_size !== want.cell_size)
          flag_error($sformatf("cell_size %0d, expected %0d", res_ch.cell_size, want.cell_size));
        if (res_ch.best_size !== want.best_size)
          flag_error($sformatf("best_size %0d, expected %0d", res_ch.best_size, want.best_size));
        if (res_ch.best_row !== want.best_row)
          flag_error($sformatf("best_row %0d, expected %0d", res_ch.best_row, want.best_row));
        if (res_ch.best_col !== want.best_col)
          flag_error($sformatf("best_col %0d, expected %0d", res_ch.best_col, want.best_col));
        if (res_ch.map_done !== want.map_done)
          flag_error($sformatf("map_done %0b, expected %0b", res_ch.map_done, want.map_done));
      end
    end
  end

  initial begin : stimulus
    square_result_t got;
    size_t          dim_r;
    size_t          dim_c;
    int unsigned    density;
    int unsigned    random_sent;
    bit             changed;
    cell_ch.valid <= 1'b0;
    cell_ch.cell_free <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_MAP_ROWS;
    cfg_ch.data <= '0;
    rst_n <= 1'b0;
    rows_cfg = size_t'(1);
    cols_cfg = size_t'(1);
    foreach (line_sizes[i]) line_sizes[i] = '0;
    restart_map();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_CFG) begin
        settle();
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        send_cell(PLAN[i].value[0], 0, PLAN[i].typed, PLAN[i].want, got);
      end
    end

    // A full-width row writes every line buffer entry; the output is held off once, near its start.
    settle();
    write_reg(REG_MAP_ROWS, size_t'(1));
    write_reg(REG_MAP_COLS, size_t'(GRID_COLS));
    hold_request = 1'b1;
    gaps_on = 1'b0;
    do send_cell($urandom_range(0, 7) != 0, 0, 1'b0, NO_RESULT, got); while (!got.map_done);

    settle();
    write_reg(REG_MAP_ROWS, size_t'(TALL_ROWS));
    write_reg(REG_MAP_COLS, size_t'(1));
    gaps_on = 1'b1;
    do send_cell($urandom_range(0, 1), gap_len(), 1'b0, NO_RESULT, got); while (!got.map_done);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      dim_r = pick_dim(20);
      dim_c = pick_dim(40);
      settle();
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_MAP_ROWS, dim_r);
        write_reg(REG_MAP_COLS, dim_c);
      end else begin
        write_reg(REG_MAP_COLS, dim_c);
        write_reg(REG_MAP_ROWS, dim_r);
      end
      case ($urandom_range(0, 3))
        0: density = 40;
        1: density = 80;
        2: density = 95;
        default: density = 100;
      endcase
      gaps_on = $urandom_range(0, 3) != 0;
      changed = 1'b0;
      do begin
        if (!changed && $urandom_range(0, 149) == 0) begin
          changed = 1'b1;
          settle();
          write_reg(cfg_reg_e'($urandom_range(0, 1)), pick_dim(20));
        end
        send_cell($urandom_range(0, 99) < density, gap_len(), 1'b0, NO_RESULT, got);
        random_sent++;
        calm = (random_sent + CALM_ITEMS >= RANDOM_ITEMS);
      end while (!got.map_done);
    end

    settle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (expected_results.size() != 0) flag_error("expected results left over at end of run");
    if (error_count == 0) begin
      $display("largest_square_finder_top verification clean");
    end else begin
      $display("largest_square_finder_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("largest_square_finder_top verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lsfind_pkg.sv
design/lsfind_if.sv
design/lsfind_line_mem.sv
design/largest_square_finder_top.sv
bench/tb.sv
